>>> src/uniform_border_trim_unit_macros.svh
// ----------------------------------------------------------------------------
// uniform border trim unit assertion macros
// concurrent assertion shorthands clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef UNIFORM_BORDER_TRIM_UNIT_MACROS_SVH
`define UNIFORM_BORDER_TRIM_UNIT_MACROS_SVH

// same-cycle implication
`define UBT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ubt_pkg.sv
// ----------------------------------------------------------------------------
// ubt_pkg
// shared types and constants of the uniform border trim unit
// ----------------------------------------------------------------------------
package ubt_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;
    localparam int SIZE_W    = 12;
    localparam int CHAN_W    = 8;
    localparam int OUT_W     = 12;

    localparam logic [3:0] EN_TOP    = 4'b1000;
    localparam logic [3:0] EN_BOTTOM = 4'b0100;
    localparam logic [3:0] EN_LEFT   = 4'b0010;
    localparam logic [3:0] EN_RIGHT  = 4'b0001;

    localparam logic [3:0]        EDGE_ENABLE_RST = 4'b1111;
    localparam logic [SIZE_W-1:0] SIZE_RST        = 12'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDGE_ENABLE  = 3'd0,
        CFG_LOW_COLOR    = 3'd1,
        CFG_HIGH_COLOR   = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]        edge_enable;
        logic [CFG_W-1:0]  low_color;
        logic [CFG_W-1:0]  high_color;
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
        logic data;
    } t_q_stat;

    typedef enum logic [2:0] {
        S_RUN,
        S_FLUSH,
        S_L_RD,
        S_L_CK,
        S_R_RD,
        S_R_CK,
        S_OUT
    } t_state;

endpackage

>>> src/ubt_if.sv
// ----------------------------------------------------------------------------
// ubt_if
// valid/ready channels of the uniform border trim unit
// ----------------------------------------------------------------------------
interface ubt_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ubt_pkg::CHAN_W-1:0] chan0;
    logic [ubt_pkg::CHAN_W-1:0] chan1;
    logic [ubt_pkg::CHAN_W-1:0] chan2;

    modport source (output valid, output chan0, output chan1, output chan2, input ready);
    modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

interface ubt_res_if;
    logic                      valid;
    logic                      ready;
    logic [ubt_pkg::OUT_W-1:0] top_trim;
    logic [ubt_pkg::OUT_W-1:0] bottom_trim;
    logic [ubt_pkg::OUT_W-1:0] left_trim;
    logic [ubt_pkg::OUT_W-1:0] right_trim;

    modport source (output valid, output top_trim, output bottom_trim,
                    output left_trim, output right_trim, input ready);
    modport sink   (input valid, input top_trim, input bottom_trim,
                    input left_trim, input right_trim, output ready);
endinterface

interface ubt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ubt_pkg::CFG_IDX_W-1:0] index;
    logic [ubt_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/ubt_front.sv
// ----------------------------------------------------------------------------
// ubt_front
// configuration registers and per-pixel colour range classification
// ----------------------------------------------------------------------------
module ubt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ubt_cfg_if.sink          i_cfg,
    ubt_pix_if.sink          i_pix,
    input  ubt_pkg::t_q_stat i_q_stat,
    output ubt_pkg::t_cfg    o_cfg,
    output logic             o_push,
    output logic             o_match
);

    ubt_pkg::t_cfg r_cfg;
    logic          ok0, ok1, ok2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edge_enable  <= ubt_pkg::EDGE_ENABLE_RST;
            r_cfg.low_color    <= '0;
            r_cfg.high_color   <= '0;
            r_cfg.image_width  <= ubt_pkg::SIZE_RST;
            r_cfg.image_height <= ubt_pkg::SIZE_RST;
        end else if (i_cfg.valid) begin
            unique case (ubt_pkg::t_cfg_idx'(i_cfg.index))
                ubt_pkg::CFG_EDGE_ENABLE:  r_cfg.edge_enable  <= i_cfg.data[3:0];
                ubt_pkg::CFG_LOW_COLOR:    r_cfg.low_color    <= i_cfg.data;
                ubt_pkg::CFG_HIGH_COLOR:   r_cfg.high_color   <= i_cfg.data;
                ubt_pkg::CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg.data[11:0];
                ubt_pkg::CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg.data[11:0];
                default: ;
            endcase
        end
    end

    assign ok0 = (i_pix.chan0 >= r_cfg.low_color[7:0])
              && (i_pix.chan0 <= r_cfg.high_color[7:0]);
    assign ok1 = (i_pix.chan1 >= r_cfg.low_color[15:8])
              && (i_pix.chan1 <= r_cfg.high_color[15:8]);
    assign ok2 = (i_pix.chan2 >= r_cfg.low_color[23:16])
              && (i_pix.chan2 <= r_cfg.high_color[23:16]);

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !i_q_stat.full;
    assign o_push      = i_pix.valid && !i_q_stat.full;
    assign o_match     = ok0 && ok1 && ok2;
    assign o_cfg       = r_cfg;

endmodule

>>> src/ubt_queue.sv
// ----------------------------------------------------------------------------
// ubt_queue
// short fifo of pixel match flags between front and back
// ----------------------------------------------------------------------------
module ubt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_data,
    input  logic             i_pop,
    output ubt_pkg::t_q_stat o_stat
);

    localparam int DEPTH = ubt_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign do_push = i_push && (r_count != CW'(DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.data  = r_mem[r_rd_ptr];

endmodule

>>> src/ubt_back.sv
// ----------------------------------------------------------------------------
// ubt_back
// raster position tracking, row counters, column flag memory and edge scans
// ----------------------------------------------------------------------------
module ubt_back #(
    parameter int MAX_WIDTH  = ubt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ubt_pkg::MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ubt_pkg::t_cfg    i_cfg,
    input  ubt_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    ubt_res_if.source        o_res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    ubt_pkg::t_state r_state, n_state;

    logic          r_colmem [MAX_WIDTH];
    logic          r_rd;
    logic [AW-1:0] rd_addr;

    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_row_full;
    logic [HW-1:0] r_top_cnt;
    logic          r_top_open;
    logic [HW-1:0] r_tail;

    logic          r_b_valid;
    logic [AW-1:0] r_b_addr;
    logic          r_b_m;
    logic          r_b_row0;
    logic          r_fwd;
    logic          r_fwd_val;
    logic          wval;

    logic [HW-1:0] r_top_res, r_bot_res;
    logic [WW-1:0] r_w, r_left, r_right, r_c;

    logic                      r_out_valid;
    logic [ubt_pkg::OUT_W-1:0] r_out_top, r_out_bot, r_out_left, r_out_right;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic          m, row0, row_full_n, row_end, frame_end, out_load;
    logic          en_top, en_bot, en_left, en_right;
    logic [HW-1:0] top_new, tail_new, top_sel, top_cap, bot_lim, bot_val;

    // frame size clamp
    always_comb begin
        if (i_cfg.image_width == '0) begin
            w = WW'(1);
        end else if (32'(i_cfg.image_width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            h = HW'(1);
        end else if (32'(i_cfg.image_height) > 32'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_cfg.image_height);
        end
    end

    assign en_top   = (i_cfg.edge_enable & ubt_pkg::EN_TOP) != '0;
    assign en_bot   = (i_cfg.edge_enable & ubt_pkg::EN_BOTTOM) != '0;
    assign en_left  = (i_cfg.edge_enable & ubt_pkg::EN_LEFT) != '0;
    assign en_right = (i_cfg.edge_enable & ubt_pkg::EN_RIGHT) != '0;

    assign m          = i_q_stat.data;
    assign row0       = (r_row == '0);
    assign row_full_n = r_row_full && m;
    assign row_end    = (WW'(r_col) + WW'(1)) >= w;
    assign frame_end  = row_end && ((HW'(r_row) + HW'(1)) >= h);

    assign top_new  = (r_top_open && row_full_n) ? r_top_cnt + HW'(1) : r_top_cnt;
    assign tail_new = row_full_n ? r_tail + HW'(1) : '0;
    assign top_sel  = en_top ? top_new : '0;
    assign top_cap  = (top_sel > h) ? h : top_sel;
    assign bot_lim  = h - top_cap;
    assign bot_val  = !en_bot ? '0 : ((tail_new > bot_lim) ? bot_lim : tail_new);

    assign wval = r_b_row0 ? r_b_m : ((r_fwd ? r_fwd_val : r_rd) & r_b_m);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ubt_pkg::S_RUN: begin
                if (o_pop && frame_end) begin
                    n_state = ubt_pkg::S_FLUSH;
                end
            end
            ubt_pkg::S_FLUSH: begin
                priority if (en_left) begin
                    n_state = ubt_pkg::S_L_RD;
                end else if (en_right) begin
                    n_state = ubt_pkg::S_R_RD;
                end else begin
                    n_state = ubt_pkg::S_OUT;
                end
            end
            ubt_pkg::S_L_RD: begin
                if (r_left >= r_w) begin
                    n_state = en_right ? ubt_pkg::S_R_RD : ubt_pkg::S_OUT;
                end else begin
                    n_state = ubt_pkg::S_L_CK;
                end
            end
            ubt_pkg::S_L_CK: begin
                if (r_rd) begin
                    n_state = ubt_pkg::S_L_RD;
                end else begin
                    n_state = en_right ? ubt_pkg::S_R_RD : ubt_pkg::S_OUT;
                end
            end
            ubt_pkg::S_R_RD: begin
                n_state = (r_c <= r_left) ? ubt_pkg::S_OUT : ubt_pkg::S_R_CK;
            end
            ubt_pkg::S_R_CK: begin
                n_state = r_rd ? ubt_pkg::S_R_RD : ubt_pkg::S_OUT;
            end
            ubt_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = ubt_pkg::S_RUN;
                end
            end
            default: n_state = ubt_pkg::S_RUN;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        rd_addr  = r_col;
        unique case (r_state)
            ubt_pkg::S_RUN:  o_pop    = !i_q_stat.empty;
            ubt_pkg::S_L_RD: rd_addr  = AW'(r_left);
            ubt_pkg::S_R_RD: rd_addr  = AW'(r_c - WW'(1));
            ubt_pkg::S_OUT:  out_load = !r_out_valid || o_res.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ubt_pkg::S_RUN;
            r_col       <= '0;
            r_row       <= '0;
            r_row_full  <= 1'b1;
            r_top_cnt   <= '0;
            r_top_open  <= 1'b1;
            r_tail      <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_b_valid <= o_pop;
            if (o_pop) begin
                if (!row_end) begin
                    r_row_full <= row_full_n;
                    r_col      <= r_col + AW'(1);
                end else if (!frame_end) begin
                    r_row_full <= 1'b1;
                    r_col      <= '0;
                    r_row      <= r_row + RW'(1);
                    r_top_cnt  <= top_new;
                    r_top_open <= r_top_open && row_full_n;
                    r_tail     <= tail_new;
                end else begin
                    r_row_full <= 1'b1;
                    r_col      <= '0;
                    r_row      <= '0;
                    r_top_cnt  <= '0;
                    r_top_open <= 1'b1;
                    r_tail     <= '0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // column flag memory, read-modify-write with one-deep forwarding
    always_ff @(posedge i_clk) begin
        r_rd <= r_colmem[rd_addr];
        if (r_b_valid) begin
            r_colmem[r_b_addr] <= wval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_addr  <= r_col;
        r_b_m     <= m;
        r_b_row0  <= row0;
        r_fwd     <= o_pop && r_b_valid && (r_b_addr == r_col);
        r_fwd_val <= wval;
        if (o_pop && frame_end) begin
            r_top_res <= top_cap;
            r_bot_res <= bot_val;
            r_w       <= w;
        end
        unique case (r_state)
            ubt_pkg::S_FLUSH: begin
                r_left  <= '0;
                r_right <= '0;
                r_c     <= r_w;
            end
            ubt_pkg::S_L_CK: begin
                if (r_rd) begin
                    r_left <= r_left + WW'(1);
                end
            end
            ubt_pkg::S_R_CK: begin
                if (r_rd) begin
                    r_right <= r_right + WW'(1);
                    r_c     <= r_c - WW'(1);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_top   <= ubt_pkg::OUT_W'(r_top_res);
            r_out_bot   <= ubt_pkg::OUT_W'(r_bot_res);
            r_out_left  <= ubt_pkg::OUT_W'(r_left);
            r_out_right <= ubt_pkg::OUT_W'(r_right);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.top_trim    = r_out_top;
    assign o_res.bottom_trim = r_out_bot;
    assign o_res.left_trim   = r_out_left;
    assign o_res.right_trim  = r_out_right;

endmodule

>>> src/uniform_border_trim_unit.sv
// queue: a pixel's match flag is registered in the queue on acceptance, leaves behind older ones
// throughput: one pixel per cycle within a frame, input stalls once the queue fills at a frame end
// frame end: after the last pixel leaves the queue, the result goes through S_FLUSH, the
//   enabled left and right column scans over the single read port of the flag memory,
//   and S_OUT, which waits for the previous result to be taken
// reset: synchronous, clears control and config, column flag memory is not cleared
// ----------------------------------------------------------------------------
// uniform_border_trim_unit
// detects uniform-colour border rows and columns of a raster frame
// ----------------------------------------------------------------------------
module uniform_border_trim_unit #(
    parameter int MAX_WIDTH  = ubt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ubt_pkg::MAX_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ubt_cfg_if.sink   i_cfg,
    ubt_pix_if.sink   i_pix,
    ubt_res_if.source o_res
);

    ubt_pkg::t_cfg    cfg;
    ubt_pkg::t_q_stat q_stat;
    logic             push, match, pop;

    ubt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_pix    (i_pix),
        .i_q_stat (q_stat),
        .o_cfg    (cfg),
        .o_push   (push),
        .o_match  (match)
    );

    ubt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (match),
        .i_pop   (pop),
        .o_stat  (q_stat)
    );

    ubt_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

>>> src/ubt_checker.sv
// ----------------------------------------------------------------------------
// ubt_checker
// port-level checks of the uniform border trim unit result channel
// ----------------------------------------------------------------------------
`include "uniform_border_trim_unit_macros.svh"

module ubt_checker #(
    parameter int MAX_WIDTH  = ubt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ubt_pkg::MAX_HEIGHT_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic [ubt_pkg::OUT_W-1:0] i_top,
    input logic [ubt_pkg::OUT_W-1:0] i_bottom,
    input logic [ubt_pkg::OUT_W-1:0] i_left,
    input logic [ubt_pkg::OUT_W-1:0] i_right
);

    logic [15:0] sum_tb, sum_lr;
    logic [4*ubt_pkg::OUT_W-1:0] res_bus;

    assign sum_tb  = 16'(i_top) + 16'(i_bottom);
    assign sum_lr  = 16'(i_left) + 16'(i_right);
    assign res_bus = {i_top, i_bottom, i_left, i_right};

    `UBT_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid, "result dropped while stalled")
    `UBT_ASSERT_NEXT(a_res_stable, i_res_valid && !i_res_ready, $stable(res_bus), "result changed while stalled")
    `UBT_ASSERT_SAME(a_rows_fit, i_res_valid, sum_tb <= 16'(MAX_HEIGHT), "top plus bottom exceeds height")
    `UBT_ASSERT_SAME(a_cols_fit, i_res_valid, sum_lr <= 16'(MAX_WIDTH), "left plus right exceeds width")

endmodule

bind uniform_border_trim_unit ubt_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_top       (o_res.top_trim),
    .i_bottom    (o_res.bottom_trim),
    .i_left      (o_res.left_trim),
    .i_right     (o_res.right_trim)
);
